>>> rtl/core/sbpl_pkg.sv
// shared types, band edges and log height table for the band peak meter
package sbpl_pkg;

  localparam int BAND_COUNT     = 16;
  localparam int BINS_PER_FRAME = 256;
  localparam int PEAK_SHIFT     = 7;

  localparam int BIN_W   = 16;
  localparam int PEAK_W  = 15;
  localparam int COUNT_W = 8;
  localparam int BAND_W  = 4;
  localparam int LEVEL_W = 8;
  localparam int HEIGHT_W = 8;

  localparam logic [COUNT_W-1:0] LAST_BIN = COUNT_W'(BINS_PER_FRAME - 1);
  localparam logic [BAND_W-1:0]  LAST_BAND = BAND_W'(BAND_COUNT - 1);

  typedef logic [COUNT_W-1:0]  band_end_t [BAND_COUNT];
  typedef logic [HEIGHT_W-1:0] log_lut_t [2**LEVEL_W];

  // one past the last bin of each band
  localparam band_end_t BAND_END = '{
    8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14, 8'd20,
    8'd28, 8'd40, 8'd54, 8'd74, 8'd101, 8'd137, 8'd187, 8'd255
  };

  // one bin beat
  typedef struct packed {
    logic signed [BIN_W-1:0] bin_value;
    logic                    frame_end;
  } bin_beat_t;

  // one band result beat
  typedef struct packed {
    logic [BAND_W-1:0]   band_index;
    logic [HEIGHT_W-1:0] height;
    logic                last_band;
  } band_res_t;

  // floor(32*log2(v)) as the top set bit of v^32, zero for v = 0
  function automatic log_lut_t build_log_lut();
    log_lut_t     lut;
    logic [255:0] acc;
    int           top;
    for (int v = 0; v < 2**LEVEL_W; v++) begin
      acc = 256'(v);
      for (int k = 0; k < 5; k++) begin
        acc = acc * acc;
      end
      top = 0;
      for (int b = 0; b < 256; b++) begin
        if (acc[b]) begin
          top = b;
        end
      end
      lut[v] = HEIGHT_W'(top);
    end
    return lut;
  endfunction

  localparam log_lut_t LOG_LUT = build_log_lut();

endpackage

>>> rtl/core/sbpl_in_reg.sv
// input register stage for bin beats
module sbpl_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sbpl_pkg::bin_beat_t in_beat,
  output logic               s1_valid,
  output sbpl_pkg::bin_beat_t s1_beat,
  input  logic               s1_take
);
  import sbpl_pkg::*;

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  bin_beat_t s1_beat_r;

  // stage is free when empty or when its beat moves on this cycle
  assign in_ready = !s1_valid_r || s1_take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_beat_r <= in_beat;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = s1_beat_r;

endmodule

>>> rtl/core/sbpl_band_core.sv
// band tracking, peak hold, log height lookup and result register
module sbpl_band_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  sbpl_pkg::bin_beat_t s1_beat,
  output logic                s1_take,
  output logic                out_valid,
  input  logic                out_ready,
  output sbpl_pkg::band_res_t out_res
);
  import sbpl_pkg::*;

  logic [COUNT_W-1:0] bin_count_r, bin_count_nxt;
  logic [BAND_W-1:0]  band_r, band_nxt;
  logic [PEAK_W-1:0]  peak_r, peak_nxt;
  logic               out_valid_r, out_valid_nxt;
  band_res_t          res_r, res_nxt;

  logic               proc;
  logic               wrap;
  logic               emit;
  logic [COUNT_W-1:0] pos_inc;
  logic [PEAK_W-1:0]  peak_upd;
  logic [LEVEL_W-1:0] level;

  // beat leaves the input stage whenever the result slot can take it
  assign s1_take = !out_valid_r || out_ready;
  assign proc    = s1_valid && s1_take;

  // frame end, marked or implied by the last bin position
  assign wrap    = s1_beat.frame_end || (bin_count_r == LAST_BIN);
  assign pos_inc = bin_count_r + COUNT_W'(1);

  // running max, negative bins never raise it
  always_comb begin
    peak_upd = peak_r;
    if (!s1_beat.bin_value[BIN_W-1] && (s1_beat.bin_value[PEAK_W-1:0] > peak_r)) begin
      peak_upd = s1_beat.bin_value[PEAK_W-1:0];
    end
  end

  assign emit  = !wrap && (pos_inc == BAND_END[band_r]);
  assign level = peak_upd[PEAK_SHIFT +: LEVEL_W];

  // next state and result
  always_comb begin
    bin_count_nxt = bin_count_r;
    band_nxt      = band_r;
    peak_nxt      = peak_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    if (proc) begin
      if (wrap) begin
        bin_count_nxt = '0;
        band_nxt      = '0;
        peak_nxt      = '0;
      end else begin
        bin_count_nxt = pos_inc;
        peak_nxt      = peak_upd;
        if (emit) begin
          peak_nxt           = '0;
          band_nxt           = band_r + BAND_W'(1);
          out_valid_nxt      = 1'b1;
          res_nxt.band_index = band_r;
          res_nxt.height     = LOG_LUT[level];
          res_nxt.last_band  = (band_r == LAST_BAND);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= '0;
      band_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bin_count_r <= bin_count_nxt;
      band_r      <= band_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // frame end clears all tracking state
  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && wrap) |=> (bin_count_r == '0 && band_r == '0 && peak_r == '0))
    else $error("tracking state not cleared at frame end");

  // each emitted band advances the band number by one
  a_band_step: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && emit) |=> (band_r == $past(band_r) + BAND_W'(1)))
    else $error("band number did not advance after result");

  // frame start implies band zero
  a_start_band: assert property (@(posedge clk) disable iff (!rst_n)
    (bin_count_r == '0) |-> (band_r == '0))
    else $error("band number nonzero at frame start");

  // a result is only loaded into a free slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !proc)
    else $error("result register overwritten while stalled");

endmodule

>>> rtl/core/spectrum_band_peak_log.sv
// Log-band spectrum peak meter: one signed bin per beat, one height per band.
// A band's last bin is first captured in the input register, then band logic and
// the log table feed the result register, which offers the result; while the
// result register is full and not taken, the bin waits in the input register.
// Throughput: one bin per cycle, limited only by the output ready.
// Reset: synchronous active-low rst_n clears bin count, band number, peak and
// both valid flags; the next bin accepted is bin 0 of a frame.
module spectrum_band_peak_log (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [sbpl_pkg::BIN_W-1:0] in_bin_value,
  input  logic                           in_frame_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sbpl_pkg::BAND_W-1:0]    out_band_index,
  output logic [sbpl_pkg::HEIGHT_W-1:0]  out_height,
  output logic                           out_last_band
);
  import sbpl_pkg::*;

  bin_beat_t in_beat;
  bin_beat_t s1_beat;
  logic      s1_valid;
  logic      s1_take;
  band_res_t out_res;

  assign in_beat.bin_value = in_bin_value;
  assign in_beat.frame_end = in_frame_end;

  // input stage
  sbpl_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat),
    .s1_take  (s1_take)
  );

  // band tracking and result register
  sbpl_band_core u_band_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_beat   (s1_beat),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_band_index = out_res.band_index;
  assign out_height     = out_res.height;
  assign out_last_band  = out_res.last_band;

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the log-band spectrum peak meter
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 8;

  // last bin of each band plus one
  localparam logic [7:0] BAND_STOP [16] = '{
    8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14, 8'd20,
    8'd28, 8'd40, 8'd54, 8'd74, 8'd101, 8'd137, 8'd187, 8'd255
  };

  typedef enum int {
    FRAME_CLEAN,
    FRAME_EARLY_END,
    FRAME_NO_END,
    FRAME_NOISE
  } frame_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic signed [sbpl_pkg::BIN_W-1:0]    in_bin_value = '0;
  logic                                 in_frame_end = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [sbpl_pkg::BAND_W-1:0]          out_band_index;
  logic [sbpl_pkg::HEIGHT_W-1:0]        out_height;
  logic                                 out_last_band;

  // bins waiting to be sent and band heights waiting to come out
  sbpl_pkg::bin_beat_t bin_queue [$];
  sbpl_pkg::band_res_t band_heights_due [$];

  // predicted meter state
  logic [7:0]  pos_in_frame = '0;
  logic [3:0]  cur_band = '0;
  logic [14:0] band_max = '0;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int src_gap = 0;
  int snk_gap = 0;
  int err_count = 0;
  int cycle_count = 0;

  spectrum_band_peak_log u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_bin_value  (in_bin_value),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_band_index(out_band_index),
    .out_height    (out_height),
    .out_last_band (out_last_band)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(32*log2(level)) as the position of the top bit of level^32
  function automatic logic [7:0] log_height_of(input logic [7:0] level);
    logic [255:0] pw;
    int           h;
    if (level == 8'd0) return 8'd0;
    pw = 256'(level);
    repeat (5) pw = pw * pw;
    h = 0;
    while ((pw >> (h + 1)) != 256'd0) h++;
    return 8'(h);
  endfunction

  // advance the meter by one bin, returns 1 when a band closes
  function automatic bit meter_step(input logic signed [15:0] val, input logic fend,
                                    output sbpl_pkg::band_res_t res);
    res = '0;
    // explicit or implied bin 255: drop everything and restart the frame
    if (fend || pos_in_frame == 8'd255) begin
      pos_in_frame = '0;
      cur_band = '0;
      band_max = '0;
      return 1'b0;
    end
    if (!val[15] && val[14:0] > band_max) band_max = val[14:0];
    pos_in_frame = pos_in_frame + 8'd1;
    if (pos_in_frame == BAND_STOP[cur_band]) begin
      res.band_index = cur_band;
      res.height = log_height_of(8'(band_max >> 7));
      res.last_band = (cur_band == 4'd15);
      band_max = '0;
      cur_band = cur_band + 4'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // bin values spread over sign, full range and log-spaced magnitudes
  function automatic logic signed [15:0] draw_bin();
    int pick;
    int mag;
    pick = $urandom_range(9);
    if (pick < 2) return 16'($urandom);
    if (pick < 4) return {1'b1, 15'($urandom)};
    mag = $urandom_range(15);
    return 16'($urandom) & 16'((32'd1 << mag) - 1);
  endfunction

  function automatic void add_bin(input logic signed [15:0] val, input logic fend);
    sbpl_pkg::bin_beat_t b;
    b.bin_value = val;
    b.frame_end = fend;
    bin_queue.push_back(b);
  endfunction

  task automatic queue_frame(input frame_kind_e kind);
    int stop;
    case (kind)
      FRAME_CLEAN: begin
        repeat (255) add_bin(draw_bin(), 1'b0);
        add_bin(16'($urandom), 1'b1);
      end
      FRAME_EARLY_END: begin
        stop = $urandom_range(0, 254);
        repeat (stop) add_bin(draw_bin(), 1'b0);
        add_bin(16'($urandom), 1'b1);
      end
      FRAME_NO_END: begin
        repeat (256) add_bin(draw_bin(), 1'b0);
      end
      FRAME_NOISE: begin
        repeat (40) add_bin(draw_bin(), 1'($urandom_range(7) == 0));
      end
      default: ;
    endcase
  endtask

  // hold the sender until every queued bin is taken and every height is back
  task automatic wait_drained();
    @(negedge clk);
    while (bin_queue.size() != 0 || in_valid || band_heights_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // input driver with random idle bursts
  always @(posedge clk) begin : drive
    sbpl_pkg::bin_beat_t nb;
    sbpl_pkg::band_res_t res;
    bit fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        if (meter_step(in_bin_value, in_frame_end, res)) band_heights_due.push_back(res);
      end
      if (in_valid && !fire) begin
        // hold the beat until taken
      end else if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (bin_queue.size() != 0 && src_idle_pct > 0 &&
                   $urandom_range(99) < src_idle_pct) begin
        src_gap = $urandom_range(3);
        in_valid <= 1'b0;
      end else if (bin_queue.size() != 0) begin
        nb = bin_queue.pop_front();
        in_valid <= 1'b1;
        in_bin_value <= nb.bin_value;
        in_frame_end <= nb.frame_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and ready stalls
  always @(posedge clk) begin : watch
    sbpl_pkg::band_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (band_heights_due.size() == 0) begin
          flag_error($sformatf("unexpected beat band=%0d height=%0d last=%0b",
                               out_band_index, out_height, out_last_band));
        end else begin
          want = band_heights_due.pop_front();
          if (out_band_index !== want.band_index || out_height !== want.height ||
              out_last_band !== want.last_band)
            flag_error($sformatf("expected band=%0d height=%0d last=%0b, got band=%0d height=%0d last=%0b",
                                 want.band_index, want.height, want.last_band,
                                 out_band_index, out_height, out_last_band));
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_ready <= 1'b0;
      end else if (snk_idle_pct > 0 && $urandom_range(99) < snk_idle_pct) begin
        snk_gap = $urandom_range(3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, sign handling, band edges, early frame ends
    add_bin(16'sh7FFF, 1'b0);
    add_bin(-16'sh8000, 1'b0);
    add_bin(16'sd127, 1'b0);
    add_bin(16'sd128, 1'b0);
    add_bin(-16'sd1, 1'b0);
    add_bin(16'sd256, 1'b0);
    add_bin(16'sd255, 1'b0);
    add_bin(16'sh4000, 1'b0);
    add_bin(16'sd0, 1'b0);
    add_bin(16'sh7F80, 1'b0);
    add_bin(16'sh5555, 1'b0);
    add_bin(16'sh7FFF, 1'b1);
    add_bin(-16'sh8000, 1'b1);
    add_bin(16'shAAAA, 1'b0);
    add_bin(16'sh2AAA, 1'b0);
    add_bin(16'sh0080, 1'b0);
    add_bin(16'sh00FF, 1'b0);
    add_bin(16'sh7FFF, 1'b0);
    add_bin(16'shFFFF, 1'b1);
    wait_drained();

    // busy random frames with idling on both sides
    src_idle_pct = 20;
    snk_idle_pct = 20;
    queue_frame(FRAME_CLEAN);
    queue_frame(FRAME_NOISE);
    queue_frame(FRAME_EARLY_END);
    queue_frame(FRAME_CLEAN);
    wait_drained();

    // back-pressure heavy phase, missing frame end included
    src_idle_pct = 5;
    snk_idle_pct = 35;
    queue_frame(FRAME_CLEAN);
    queue_frame(FRAME_NO_END);
    queue_frame(FRAME_EARLY_END);
    wait_drained();

    // full rate to the end
    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_frame(FRAME_CLEAN);
    queue_frame(FRAME_CLEAN);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && band_heights_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
